// ===== design/ring_buffer_cache_allocator_macros.svh =====
// Assertion macros for the ring buffer cache allocator
`ifndef RING_BUFFER_CACHE_ALLOCATOR_MACROS_SVH
`define RING_BUFFER_CACHE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define RBCA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define RBCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rbca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbca_pkg
// Shared types and codes of the ring buffer cache allocator.
// ----------------------------------------------------------------------------
package rbca_pkg;

    localparam int DIV_W     = 22;
    localparam int OFF_W     = 20;
    localparam int STATUS_W  = 2;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_ALLOC  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG = 2'd2;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_LK_RECENT,
        S_WALK_RD,
        S_WALK_CHK,
        S_AL_START,
        S_AL_RD,
        S_AL_LOAD,
        S_AL_CHK,
        S_AL_RDA,
        S_AL_MRG,
        S_AL_FIN,
        S_AL_SPLIT
    } state_t;

endpackage

// ===== design/ring_buffer_cache_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_cache_allocator
// Ring allocator of variable-size runs with eviction, plus key lookup.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_ready): action, key_high, key_low,
// request_bytes. Output channel (out_valid / out_ready): status, data_offset.
// One transaction in gives exactly one registered transaction out.
// A lookup checks the recent list first; on a miss, a chain walk reads the run
// headers from block 0 in turn until the key matches or the chain ends. An
// oversized allocate is refused; any other reads the run at the free point,
// merges the runs after it until the request fits, wraps to block 0 when the
// end of the store is reached, and splits off any remainder.
// The request is rounded to blocks by a shift in the accept cycle.
// One transaction is worked on at a time: in_ready is low while busy and while
// a result waits, so a new transaction is taken only once the last is delivered.
// After reset the block writes the header of run 0, then raises in_ready. A
// stalled receiver holds the result in the output register and blocks new
// input until it is taken.
// ----------------------------------------------------------------------------
module ring_buffer_cache_allocator #(
    parameter int STORE_BYTES    = 1048576,
    parameter int BLOCK_BYTES    = 256,
    parameter int RECENT_ENTRIES = 5,
    parameter int HEADER_BYTES   = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           action,
    input  logic [31:0]                    key_high,
    input  logic [31:0]                    key_low,
    input  logic [20:0]                    request_bytes,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rbca_pkg::STATUS_W-1:0]  status,
    output logic [rbca_pkg::OFF_W-1:0]     data_offset
);

    localparam int NBLOCKS = STORE_BYTES / BLOCK_BYTES;
    localparam int BW      = (NBLOCKS > 1) ? $clog2(NBLOCKS) : 1;
    localparam int LW      = BW + 1;
    localparam int RW      = (RECENT_ENTRIES > 1) ? $clog2(RECENT_ENTRIES) : 1;
    localparam int MW      = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam int PW      = BW + 18;

    function automatic logic [rbca_pkg::OFF_W-1:0] payload_offset(input logic [BW-1:0] blk);
        logic [PW-1:0] full;
        full = PW'(blk) * PW'(BLOCK_BYTES) + PW'(HEADER_BYTES);
        return full[rbca_pkg::OFF_W-1:0];
    endfunction

    rbca_pkg::state_t state_reg, state_next;

    logic [31:0]                     kh_reg, kh_next;
    logic [31:0]                     kl_reg, kl_next;
    logic [rbca_pkg::DIV_W-1:0]      quo_reg, quo_next;
    logic [LW-1:0]                   need_reg, need_next;
    logic [BW-1:0]                   f_reg, f_next;
    logic [LW-1:0]                   lenf_reg, lenf_next;
    logic [BW-1:0]                   cur_reg, cur_next;
    logic [BW-1:0]                   free_reg, free_next;
    logic [31:0]                     rk_high_reg [RECENT_ENTRIES];
    logic [31:0]                     rk_low_reg  [RECENT_ENTRIES];
    logic [BW-1:0]                   roff_reg    [RECENT_ENTRIES];
    logic [RW-1:0]                   rnext_reg, rnext_next;
    logic                            out_valid_reg, out_valid_next;
    logic [rbca_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [rbca_pkg::OFF_W-1:0]      offset_reg, offset_next;

    logic [31:0]   mem_kh  [NBLOCKS];
    logic [31:0]   mem_kl  [NBLOCKS];
    logic [LW-1:0] mem_len [NBLOCKS];
    logic [31:0]   rd_kh, rd_kl;
    logic [LW-1:0] rd_len;
    logic [BW-1:0] rd_addr;

    logic          kh_we, kl_we, len_we;
    logic [BW-1:0] kh_waddr, kl_waddr, len_waddr;
    logic [31:0]   kh_wdata, kl_wdata;
    logic [LW-1:0] len_wdata;

    logic          accept;
    logic          rec_we;
    logic [BW-1:0] rec_blk;
    logic          rhit;
    logic [BW-1:0] rhit_off;
    logic [LW:0]   after_sum, nxt_sum, walk_sum;
    logic          wrap;
    logic [rbca_pkg::DIV_W-1:0] dividend;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == rbca_pkg::S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data_offset = offset_reg;

    assign dividend  = rbca_pkg::DIV_W'(request_bytes)
                     + rbca_pkg::DIV_W'(HEADER_BYTES + BLOCK_BYTES - 1);
    assign after_sum = (LW+1)'(f_reg) + (LW+1)'(lenf_reg);
    assign nxt_sum   = (LW+1)'(f_reg) + (LW+1)'(need_reg);
    assign walk_sum  = (LW+1)'(cur_reg) + (LW+1)'(rd_len);
    assign wrap      = (after_sum >= (LW+1)'(NBLOCKS)) || (lenf_reg == '0);

    always_comb
    begin
        rhit     = 1'b0;
        rhit_off = '0;
        for (int i = RECENT_ENTRIES - 1; i >= 0; i--)
        begin
            if (rk_high_reg[i] == kh_reg && rk_low_reg[i] == kl_reg)
            begin
                rhit     = 1'b1;
                rhit_off = roff_reg[i];
            end
        end
    end

    // next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        kh_next        = kh_reg;
        kl_next        = kl_reg;
        quo_next       = quo_reg;
        need_next      = need_reg;
        f_next         = f_reg;
        lenf_next      = lenf_reg;
        cur_next       = cur_reg;
        free_next      = free_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        offset_next    = offset_reg;
        rec_we         = 1'b0;
        rec_blk        = f_reg;
        unique case (state_reg)
            rbca_pkg::S_INIT:
            begin
                state_next = rbca_pkg::S_IDLE;
            end
            rbca_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    kh_next  = key_high;
                    kl_next  = key_low;
                    quo_next = dividend >> MW;
                    state_next = (action == rbca_pkg::ACT_ALLOC) ? rbca_pkg::S_AL_START
                                                                 : rbca_pkg::S_LK_RECENT;
                end
            end
            rbca_pkg::S_LK_RECENT:
            begin
                if (rhit)
                begin
                    out_valid_next = 1'b1;
                    status_next    = rbca_pkg::ST_OK;
                    offset_next    = payload_offset(rhit_off);
                    state_next     = rbca_pkg::S_IDLE;
                end
                else
                begin
                    cur_next   = '0;
                    state_next = rbca_pkg::S_WALK_RD;
                end
            end
            rbca_pkg::S_WALK_RD:
            begin
                state_next = rbca_pkg::S_WALK_CHK;
            end
            rbca_pkg::S_WALK_CHK:
            begin
                if (rd_kh == kh_reg && rd_kl == kl_reg)
                begin
                    rec_we         = 1'b1;
                    rec_blk        = cur_reg;
                    out_valid_next = 1'b1;
                    status_next    = rbca_pkg::ST_OK;
                    offset_next    = payload_offset(cur_reg);
                    state_next     = rbca_pkg::S_IDLE;
                end
                else if (rd_len == '0 || walk_sum >= (LW+1)'(NBLOCKS))
                begin
                    out_valid_next = 1'b1;
                    status_next    = rbca_pkg::ST_MISS;
                    offset_next    = '0;
                    state_next     = rbca_pkg::S_IDLE;
                end
                else
                begin
                    cur_next   = walk_sum[BW-1:0];
                    state_next = rbca_pkg::S_WALK_RD;
                end
            end
            rbca_pkg::S_AL_START:
            begin
                if (quo_reg > rbca_pkg::DIV_W'(NBLOCKS))
                begin
                    out_valid_next = 1'b1;
                    status_next    = rbca_pkg::ST_TOO_BIG;
                    offset_next    = '0;
                    state_next     = rbca_pkg::S_IDLE;
                end
                else
                begin
                    need_next  = quo_reg[LW-1:0];
                    f_next     = free_reg;
                    state_next = rbca_pkg::S_AL_RD;
                end
            end
            rbca_pkg::S_AL_RD:
            begin
                state_next = rbca_pkg::S_AL_LOAD;
            end
            rbca_pkg::S_AL_LOAD:
            begin
                lenf_next  = rd_len;
                state_next = rbca_pkg::S_AL_CHK;
            end
            rbca_pkg::S_AL_CHK:
            begin
                if (lenf_reg >= need_reg)
                begin
                    state_next = rbca_pkg::S_AL_FIN;
                end
                else if (wrap)
                begin
                    f_next     = '0;
                    state_next = rbca_pkg::S_AL_RD;
                end
                else
                begin
                    state_next = rbca_pkg::S_AL_RDA;
                end
            end
            rbca_pkg::S_AL_RDA:
            begin
                state_next = rbca_pkg::S_AL_MRG;
            end
            rbca_pkg::S_AL_MRG:
            begin
                lenf_next  = lenf_reg + rd_len;
                state_next = rbca_pkg::S_AL_CHK;
            end
            rbca_pkg::S_AL_FIN:
            begin
                if (nxt_sum < (LW+1)'(NBLOCKS) && lenf_reg > need_reg)
                begin
                    state_next = rbca_pkg::S_AL_SPLIT;
                end
                else
                begin
                    free_next      = (nxt_sum >= (LW+1)'(NBLOCKS)) ? '0 : nxt_sum[BW-1:0];
                    rec_we         = 1'b1;
                    out_valid_next = 1'b1;
                    status_next    = rbca_pkg::ST_OK;
                    offset_next    = payload_offset(f_reg);
                    state_next     = rbca_pkg::S_IDLE;
                end
            end
            rbca_pkg::S_AL_SPLIT:
            begin
                free_next      = nxt_sum[BW-1:0];
                rec_we         = 1'b1;
                out_valid_next = 1'b1;
                status_next    = rbca_pkg::ST_OK;
                offset_next    = payload_offset(f_reg);
                state_next     = rbca_pkg::S_IDLE;
            end
            default:
            begin
                state_next = rbca_pkg::S_IDLE;
            end
        endcase
    end

    // memory port control
    always_comb
    begin
        kh_we     = 1'b0;
        kl_we     = 1'b0;
        len_we    = 1'b0;
        kh_waddr  = f_reg;
        kl_waddr  = f_reg;
        len_waddr = f_reg;
        kh_wdata  = kh_reg;
        kl_wdata  = kl_reg;
        len_wdata = need_reg;
        rd_addr   = f_reg;
        unique case (state_reg)
            rbca_pkg::S_INIT:
            begin
                kh_we     = 1'b1;
                kl_we     = 1'b1;
                len_we    = 1'b1;
                kh_waddr  = '0;
                kl_waddr  = '0;
                len_waddr = '0;
                kh_wdata  = '0;
                kl_wdata  = '0;
                len_wdata = LW'(NBLOCKS);
            end
            rbca_pkg::S_WALK_RD:
            begin
                rd_addr = cur_reg;
            end
            rbca_pkg::S_AL_CHK:
            begin
                if (lenf_reg < need_reg && wrap)
                begin
                    kh_we    = 1'b1;
                    kh_waddr = '0;
                    kh_wdata = '0;
                end
            end
            rbca_pkg::S_AL_RDA:
            begin
                rd_addr = after_sum[BW-1:0];
            end
            rbca_pkg::S_AL_MRG:
            begin
                len_we    = 1'b1;
                len_wdata = lenf_reg + rd_len;
            end
            rbca_pkg::S_AL_FIN:
            begin
                kh_we  = 1'b1;
                kl_we  = 1'b1;
                len_we = 1'b1;
            end
            rbca_pkg::S_AL_SPLIT:
            begin
                kh_we     = 1'b1;
                len_we    = 1'b1;
                kh_waddr  = nxt_sum[BW-1:0];
                len_waddr = nxt_sum[BW-1:0];
                kh_wdata  = '0;
                len_wdata = lenf_reg - need_reg;
            end
            default:
            begin
                rd_addr = f_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (kh_we)
        begin
            mem_kh[kh_waddr] <= kh_wdata;
        end
        if (kl_we)
        begin
            mem_kl[kl_waddr] <= kl_wdata;
        end
        if (len_we)
        begin
            mem_len[len_waddr] <= len_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_kh  <= mem_kh[rd_addr];
        rd_kl  <= mem_kl[rd_addr];
        rd_len <= mem_len[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rbca_pkg::S_INIT;
            free_reg      <= '0;
            rnext_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < RECENT_ENTRIES; i++)
            begin
                rk_high_reg[i] <= '0;
                rk_low_reg[i]  <= '0;
                roff_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            rnext_reg     <= rnext_next;
            out_valid_reg <= out_valid_next;
            if (rec_we)
            begin
                rk_high_reg[rnext_reg] <= kh_reg;
                rk_low_reg[rnext_reg]  <= kl_reg;
                roff_reg[rnext_reg]    <= rec_blk;
            end
        end
    end

    always_comb
    begin
        rnext_next = rnext_reg;
        if (rec_we)
        begin
            rnext_next = (rnext_reg == RW'(RECENT_ENTRIES - 1)) ? '0 : rnext_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        kh_reg     <= kh_next;
        kl_reg     <= kl_next;
        quo_reg    <= quo_next;
        need_reg   <= need_next;
        f_reg      <= f_next;
        lenf_reg   <= lenf_next;
        cur_reg    <= cur_next;
        status_reg <= status_next;
        offset_reg <= offset_next;
    end

endmodule

// ===== design/rbca_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbca_checker
// Port-level checks of the ring buffer cache allocator.
// ----------------------------------------------------------------------------
`include "ring_buffer_cache_allocator_macros.svh"

module rbca_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [19:0] data_offset
);

    `RBCA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(data_offset) && $stable(status), "stalled result changed")
    `RBCA_ASSERT_NOW(a_status_code, out_valid, status == rbca_pkg::ST_OK || status == rbca_pkg::ST_MISS || status == rbca_pkg::ST_TOO_BIG, "bad status code")
    `RBCA_ASSERT_NOW(a_fail_offset, out_valid && status != rbca_pkg::ST_OK, data_offset == '0, "failed transaction with offset")
    `RBCA_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "ready right after accept")

endmodule

bind ring_buffer_cache_allocator rbca_checker u_rbca_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .data_offset (data_offset)
);
